// ----- rtl/erc_pkg.sv -----
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants for the epoch reclamation engine.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int unsigned ThreadSlotsDefault = 16;
  localparam int unsigned FifoDepthDefault   = 32;
  localparam int unsigned EpochWidthDefault  = 32;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_THREAD_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EPOCH_PERIOD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCAN_PERIOD  = 2'd2;

  localparam logic [4:0] ThreadCountRst = 5'd16;
  localparam logic [7:0] EpochPeriodRst = 8'd2;
  localparam logic [5:0] ScanPeriodRst  = 6'd10;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_RETIRE = 2'd2;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FREED  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  thread_id;
    logic [31:0] node_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] freed_handle;
    logic [31:0] epoch_now;
    logic        last_result;
  } rsp_t;

endpackage

// ----- rtl/epoch_reclamation_engine.sv -----
// ----------------------------------------------------------------------------
// epoch_reclamation_engine
// Epoch based reclamation tracker with per-thread retire queues.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken when busy_o is low. Start and
// end commands answer in the cycle after acceptance. A retire writes the
// queue, then finds fill mod scan_period by repeated subtraction, one
// compare and subtract per cycle. When a scan is due it walks the
// reservations one thread per cycle through a single compare unit, then
// pops entries one at a time, each through a memory read and then a
// compare. Each result shows on result_o for one cycle with result_valid_o
// high; the receiver cannot stall, so results leave as they are made. Queue
// memory is not cleared; head/fill counters reset, so no unwritten entry is
// ever used.
// ----------------------------------------------------------------------------
module epoch_reclamation_engine
  import erc_pkg::*;
#(
  parameter int unsigned THREAD_SLOTS = ThreadSlotsDefault,
  parameter int unsigned FIFO_DEPTH   = FifoDepthDefault,
  parameter int unsigned EPOCH_WIDTH  = EpochWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  req_t                req_i,
  output logic                result_valid_o,
  output rsp_t                result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned TW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AW = TW + PW;
  localparam int unsigned CW = $clog2(THREAD_SLOTS + 1);
  localparam logic [EPOCH_WIDTH-1:0] EpochOnes = '1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PUSH  = 6'b000010,
    S_MIN   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] thread_count_q;
  logic [7:0] epoch_period_q;
  logic [5:0] scan_period_q;

  logic [EPOCH_WIDTH-1:0] resv_q [THREAD_SLOTS];
  logic [PW-1:0]          head_q [THREAD_SLOTS];
  logic [FW-1:0]          fill_q [THREAD_SLOTS];
  logic [7:0]             tally_q [THREAD_SLOTS];
  logic [EPOCH_WIDTH-1:0] epoch_q;

  // queue memory: handle and epoch tag
  logic [32+EPOCH_WIDTH-1:0] mem [THREAD_SLOTS*(2**PW)];
  logic [32+EPOCH_WIDTH-1:0] rd_q;

  logic [TW-1:0]          tid_q;
  logic [CW-1:0]          cnt_q;   // reservation walk index
  logic [EPOCH_WIDTH-1:0] min_q;
  logic                   any_q;   // a node was freed by this retire
  logic [FW-1:0]          rem_q;   // fill remainder against the scan period
  logic                   rv_q;
  rsp_t                   rsp_q;
  rsp_t                   hold_q;  // freed result waiting to learn if it is last

  logic [CW-1:0] n_thr;
  assign n_thr = (32'(thread_count_q) > THREAD_SLOTS) ? CW'(THREAD_SLOTS)
                                                       : CW'(thread_count_q);

  logic id_ok;
  assign id_ok = ({28'd0, req_i.thread_id} < 32'(THREAD_SLOTS));

  logic [7:0] per_eff;
  logic [5:0] sp_eff;
  assign per_eff = (epoch_period_q == 8'd0) ? 8'd1 : epoch_period_q;
  assign sp_eff  = (scan_period_q == 6'd0) ? 6'd1 : scan_period_q;

  logic [EPOCH_WIDTH-1:0] epoch_out;
  logic [31:0] epoch_ext;
  assign epoch_ext = 32'(epoch_q);

  logic [FW-1:0] cur_fill;
  assign cur_fill = fill_q[tid_q];

  // push slot: head + fill wraps at most once
  logic [TW-1:0] wr_tid;
  logic [31:0]   wr_sum;
  logic [PW-1:0] wr_pos;
  assign wr_tid = TW'(req_i.thread_id);
  assign wr_sum = 32'(head_q[wr_tid]) + 32'(fill_q[wr_tid]);
  assign wr_pos = (wr_sum >= FIFO_DEPTH) ? PW'(wr_sum - FIFO_DEPTH) : PW'(wr_sum);

  logic [AW-1:0] head_addr;
  assign head_addr = {tid_q, head_q[tid_q]};
  assign epoch_out = epoch_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) begin
        if (id_ok && req_i.operation == OP_RETIRE
            && fill_q[TW'(req_i.thread_id)] < FW'(FIFO_DEPTH)) state_d = S_PUSH;
        else state_d = S_IDLE;
      end
      S_PUSH:  if (32'(rem_q) < 32'(sp_eff)) state_d = (rem_q == '0) ? S_MIN : S_DONE;
      S_MIN:   if (cnt_q >= n_thr) state_d = S_READ;
      S_READ:  state_d = (cur_fill == '0) ? S_DONE : S_CHECK;
      S_CHECK: state_d = (rd_q[EPOCH_WIDTH-1:0] < min_q) ? S_READ : S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign result_o = rsp_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i && state_d == S_PUSH)
      mem[{wr_tid, wr_pos}] <= {req_i.node_handle, epoch_q};
    rd_q <= mem[head_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      thread_count_q <= ThreadCountRst;
      epoch_period_q <= EpochPeriodRst;
      scan_period_q  <= ScanPeriodRst;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        resv_q[i] <= EpochOnes;
        head_q[i] <= '0;
        fill_q[i] <= '0;
        tally_q[i] <= '0;
      end
      epoch_q <= EPOCH_WIDTH'(1);
      rv_q <= 1'b0;
      rsp_q <= '0;
      hold_q <= '0;
      tid_q <= '0;
      cnt_q <= '0;
      min_q <= '0;
      any_q <= 1'b0;
      rem_q <= '0;
    end else begin
      state_q <= state_d;
      rv_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THREAD_COUNT: thread_count_q <= cfg_data_i[4:0];
          CFG_EPOCH_PERIOD: epoch_period_q <= cfg_data_i;
          CFG_SCAN_PERIOD:  scan_period_q  <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (start_i) begin
          tid_q <= TW'(req_i.thread_id);
          any_q <= 1'b0;
          cnt_q <= '0;
          min_q <= EpochOnes;
          if (state_d != S_PUSH) begin
            rv_q <= 1'b1;
            rsp_q <= '{result_kind: (id_ok && req_i.operation == OP_RETIRE)
                                    ? KIND_REJECT : KIND_ACK,
                       freed_handle: 32'd0,
                       epoch_now: epoch_ext, last_result: 1'b1};
            if (id_ok && req_i.operation == OP_START)
              resv_q[TW'(req_i.thread_id)] <= epoch_q;
            else if (id_ok && req_i.operation == OP_END)
              resv_q[TW'(req_i.thread_id)] <= EpochOnes;
          end else begin
            fill_q[TW'(req_i.thread_id)] <= fill_q[TW'(req_i.thread_id)] + 1'b1;
            rem_q <= fill_q[TW'(req_i.thread_id)] + 1'b1;
            if (tally_q[TW'(req_i.thread_id)] + 8'd1 >= per_eff) begin
              tally_q[TW'(req_i.thread_id)] <= '0;
              epoch_q <= epoch_q + 1'b1;
            end else begin
              tally_q[TW'(req_i.thread_id)] <= tally_q[TW'(req_i.thread_id)] + 8'd1;
            end
          end
        end
        // remainder of the new fill by the scan period, one subtract a cycle
        S_PUSH: if (32'(rem_q) >= 32'(sp_eff)) rem_q <= rem_q - FW'(sp_eff);
        S_MIN: if (cnt_q < n_thr) begin
          if (resv_q[TW'(cnt_q)] < min_q) min_q <= resv_q[TW'(cnt_q)];
          cnt_q <= cnt_q + 1'b1;
        end
        S_READ: ;
        S_CHECK: if (rd_q[EPOCH_WIDTH-1:0] < min_q) begin
          // free the oldest entry; the previous one goes out as non-last
          if (any_q) begin
            rv_q <= 1'b1;
            rsp_q <= hold_q;
          end
          any_q <= 1'b1;
          hold_q <= '{result_kind: KIND_FREED,
                      freed_handle: rd_q[32+EPOCH_WIDTH-1:EPOCH_WIDTH],
                      epoch_now: 32'(epoch_out), last_result: 1'b0};
          head_q[tid_q] <= (32'(head_q[tid_q]) == FIFO_DEPTH - 1) ? '0
                                                                 : head_q[tid_q] + 1'b1;
          fill_q[tid_q] <= fill_q[tid_q] - 1'b1;
        end
        S_DONE: begin
          rv_q <= 1'b1;
          if (any_q) rsp_q <= '{result_kind: hold_q.result_kind,
                                freed_handle: hold_q.freed_handle,
                                epoch_now: hold_q.epoch_now, last_result: 1'b1};
          else rsp_q <= '{result_kind: KIND_ACK, freed_handle: 32'd0,
                          epoch_now: epoch_ext, last_result: 1'b1};
        end
        default: ;
      endcase
    end
  end

  // freed results are held one step, so each freed result is non-last
  // unless it leaves from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |=> !busy_o || $past(state_q == S_DONE)
      || $past(state_q == S_IDLE))
    else $error("last result while still working");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (fill_q[tid_q] != '0))
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind == KIND_FREED && !result_o.last_result)
      |-> busy_o)
    else $error("freed result without completion pending");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the epoch reclamation engine. A predictor
// tracks reservations, epoch, retire queues and tallies and queues expected
// result transactions; a monitor compares every result against them.
// ----------------------------------------------------------------------------
module testbench;
  import erc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 16;
  localparam int unsigned Depth = 32;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  req_t                req_i = '0;
  logic                result_valid_o;
  rsp_t                result_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  epoch_reclamation_engine u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i,
    .result_valid_o, .result_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow copy of the engine state.
  logic [4:0]  thr_count = ThreadCountRst;
  logic [7:0]  ep_period = EpochPeriodRst;
  logic [5:0]  sc_period = ScanPeriodRst;
  logic [31:0] resv [Slots];
  logic [31:0] epoch;
  logic [31:0] q_handle [Slots][Depth];
  logic [31:0] q_tag [Slots][Depth];
  int unsigned q_head [Slots];
  int unsigned q_fill [Slots];
  logic [7:0]  tally [Slots];

  req_t pending_req[$];   // commands waiting to be issued
  rsp_t expected_rsp[$];  // results predicted, not yet seen
  bit   hold_off = 1'b1;  // sender paused (config windows, drain pause)
  bit   no_idle = 1'b0;   // stretch with back-to-back commands
  int   mismatches = 0;
  int   n_accepted = 0;
  int   n_freed = 0;
  int   n_reject = 0;
  int   n_ack = 0;

  initial begin
    for (int t = 0; t < Slots; t++) begin
      resv[t] = '1;
      q_head[t] = 0;
      q_fill[t] = 0;
      tally[t] = '0;
    end
    epoch = 32'd1;
  end

  function automatic rsp_t mk_rsp(logic [1:0] kind, logic [31:0] h, logic last);
    rsp_t r;
    r.result_kind  = kind;
    r.freed_handle = h;
    r.epoch_now    = epoch;
    r.last_result  = last;
    return r;
  endfunction

  // Apply one accepted command to the shadow state and queue its results.
  task automatic predict_req(req_t rq);
    int unsigned tid, pos, per, sp, nthr, freed;
    logic [31:0] minr;
    rsp_t r;
    tid = rq.thread_id;
    if (rq.operation == OP_START) begin
      resv[tid] = epoch;
      expected_rsp.push_back(mk_rsp(KIND_ACK, '0, 1'b1));
    end else if (rq.operation == OP_END) begin
      resv[tid] = '1;
      expected_rsp.push_back(mk_rsp(KIND_ACK, '0, 1'b1));
    end else if (rq.operation != OP_RETIRE) begin
      // unknown opcode: ignored
      expected_rsp.push_back(mk_rsp(KIND_ACK, '0, 1'b1));
    end else if (q_fill[tid] >= Depth) begin
      expected_rsp.push_back(mk_rsp(KIND_REJECT, '0, 1'b1));
    end else begin
      pos = (q_head[tid] + q_fill[tid]) % Depth;
      q_handle[tid][pos] = rq.node_handle;
      q_tag[tid][pos] = epoch;
      q_fill[tid]++;
      per = (ep_period == 0) ? 1 : ep_period;
      tally[tid] = tally[tid] + 8'd1;
      if (tally[tid] >= per) begin
        tally[tid] = '0;
        epoch = epoch + 32'd1;
      end
      sp = (sc_period == 0) ? 1 : sc_period;
      freed = 0;
      if (q_fill[tid] % sp == 0) begin
        nthr = (thr_count > Slots) ? Slots : thr_count;
        minr = '1;
        for (int i = 0; i < nthr; i++) if (resv[i] < minr) minr = resv[i];
        while (q_fill[tid] > 0 && q_tag[tid][q_head[tid]] < minr) begin
          expected_rsp.push_back(mk_rsp(KIND_FREED, q_handle[tid][q_head[tid]], 1'b0));
          q_head[tid] = (q_head[tid] + 1) % Depth;
          q_fill[tid]--;
          freed++;
        end
      end
      if (freed == 0) begin
        expected_rsp.push_back(mk_rsp(KIND_ACK, '0, 1'b1));
      end else begin
        r = expected_rsp.pop_back();
        r.last_result = 1'b1;
        expected_rsp.push_back(r);
      end
    end
  endtask

  // Driver: a command transaction completes when start_i && !busy_o.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predict_req(req_i);
        n_accepted++;
      end
      if (!start_i || !busy_o) begin
        if (!hold_off && pending_req.size() > 0 &&
            (no_idle || $urandom_range(99) >= 32)) begin
          start_i <= 1'b1;
          req_i   <= pending_req.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be stalled, compare each against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind=%0d handle=%h epoch=%h last=%0b",
                   result_o.result_kind, result_o.freed_handle, result_o.epoch_now,
                   result_o.last_result);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (result_o.result_kind !== exp_r.result_kind ||
            result_o.freed_handle !== exp_r.freed_handle ||
            result_o.epoch_now !== exp_r.epoch_now ||
            result_o.last_result !== exp_r.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result exp kind=%0d h=%h ep=%h last=%0b got kind=%0d h=%h ep=%h last=%0b",
                     exp_r.result_kind, exp_r.freed_handle, exp_r.epoch_now,
                     exp_r.last_result, result_o.result_kind, result_o.freed_handle,
                     result_o.epoch_now, result_o.last_result);
        end
        case (exp_r.result_kind)
          KIND_FREED:  n_freed++;
          KIND_REJECT: n_reject++;
          default:     n_ack++;
        endcase
      end
    end
  end

  task automatic add_req(logic [1:0] op, logic [3:0] tid, logic [31:0] h);
    req_t rq;
    rq.operation = op;
    rq.thread_id = tid;
    rq.node_handle = h;
    pending_req.push_back(rq);
  endtask

  // Let everything queued run to completion, then pause the sender.
  task automatic drain();
    hold_off = 1'b0;
    wait (pending_req.size() == 0);
    @(posedge clk_i);
    hold_off = 1'b1;
    while (start_i || busy_o || expected_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register write, only issued while the engine is idle.
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_THREAD_COUNT: thr_count = val[4:0];
      CFG_EPOCH_PERIOD: ep_period = val;
      CFG_SCAN_PERIOD:  sc_period = val[5:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed start / retire burst / end sequences, plus noise.
  task automatic gen_random(int n);
    int cnt, nret;
    logic [3:0] tid;
    cnt = 0;
    while (cnt < n) begin
      tid = 4'($urandom_range(15));
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(3) != 0) begin
          add_req(OP_START, tid, $urandom);
          cnt++;
        end
        nret = $urandom_range(12, 1);
        for (int i = 0; i < nret; i++) add_req(OP_RETIRE, tid, $urandom);
        cnt += nret;
        if ($urandom_range(3) != 0) begin
          add_req(OP_END, tid, $urandom);
          cnt++;
        end
      end else begin
        add_req(2'($urandom_range(3)), tid, $urandom);
        cnt++;
      end
    end
  endtask

  initial begin
    logic [7:0] cfg_set [7][3];
    cfg_set = '{'{8'd16, 8'd2, 8'd10}, '{8'd1, 8'd1, 8'd1}, '{8'd0, 8'd255, 8'd32},
                '{8'd255, 8'd3, 8'd0}, '{8'd4, 8'd0, 8'd5}, '{8'd16, 8'd255, 8'd255},
                '{8'd8, 8'd7, 8'd16}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reservation blocks frees, then release lets the scan free all.
    add_req(OP_START, 4'd0, 32'h0);
    for (int i = 0; i < 10; i++) add_req(OP_RETIRE, 4'd1, (i == 0) ? 32'h0 : 32'hffffffff - i);
    add_req(OP_END, 4'd0, 32'hffffffff);
    for (int i = 0; i < 10; i++) add_req(OP_RETIRE, 4'd1, 32'h1000 + i);
    add_req(2'd3, 4'd15, 32'hffffffff);
    add_req(OP_START, 4'd15, 32'h0);
    add_req(OP_END, 4'd15, 32'h0);
    drain();

    // Directed: no scan can trigger, so the queue fills and retires reject.
    write_cfg(CFG_THREAD_COUNT, 8'd0);
    write_cfg(CFG_EPOCH_PERIOD, 8'd0);
    write_cfg(CFG_SCAN_PERIOD, 8'd40);
    for (int i = 0; i < 34; i++) add_req(OP_RETIRE, 4'd2, $urandom);
    drain();

    // Random phases over several register settings; one runs without idling.
    for (int p = 0; p < 7; p++) begin
      write_cfg(CFG_THREAD_COUNT, cfg_set[p][0]);
      write_cfg(CFG_EPOCH_PERIOD, cfg_set[p][1]);
      write_cfg(CFG_SCAN_PERIOD, cfg_set[p][2]);
      no_idle = (p == 3);
      gen_random(58);
      drain();
    end
    no_idle = 1'b0;
    repeat (200) @(posedge clk_i);

    $display("Covered %0d commands under 9 register settings: %0d frees, %0d rejects, %0d acks.",
             n_accepted, n_freed, n_reject, n_ack);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("epoch_reclamation_engine regression: pass");
    end else begin
      $display("Failures: %0d mismatches, %0d results never seen.",
               mismatches, expected_rsp.size());
      $display("epoch_reclamation_engine regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d results still outstanding.", expected_rsp.size());
    $display("epoch_reclamation_engine regression: fail");
    $finish;
  end

endmodule
